// ===== src/dws_pkg.sv =====
`default_nettype none
// ============================================================================
// dws_pkg
// Shared widths, register indexes, reset values and the command type that
// the stencil controller hands to its datapath.
// ============================================================================
package dws_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int COEF_W         = 16;
    localparam int IDX_W          = 12;
    localparam int CFG_IDX_W      = 2;
    localparam int MAX_POINTS_DEF = 4096;

    localparam logic [CFG_IDX_W-1:0] CFG_COURANT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECIP   = 2'd2;

    localparam logic [COEF_W-1:0] COURANT_RESET = 16'd16384;
    localparam logic [COEF_W-1:0] KEEP_RESET    = 16'd32768;
    localparam logic [COEF_W-1:0] RECIP_RESET   = 16'd32768;

    typedef struct packed {
        logic             shift_window;
        logic             load_ops;
        logic             mul1_en;
        logic             sum_en;
        logic             mul2_en;
        logic             round_en;
        logic [IDX_W-1:0] point_index;
        logic             last_point;
    } t_dp_cmd;

endpackage
`default_nettype wire

// ===== src/dws_ctrl.sv =====
`default_nettype none
// ============================================================================
// dws_ctrl
// Point counter, handshake control and step sequencer for the stencil
// datapath.
// ============================================================================
module dws_ctrl
    import dws_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_end_of_grid,
    output logic         o_in_stall,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_dp_cmd      o_cmd
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL1  = 5'b00010,
        S_SUM   = 5'b00100,
        S_MUL2  = 5'b01000,
        S_ROUND = 5'b10000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    logic               n_out_valid;
    logic               in_acc;
    logic               out_free;
    logic               full;
    logic [CNT_W-1:0]   index_w;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign full     = (r_count >= CNT_W'(MAX_POINTS));
    assign index_w  = r_count - CNT_W'(1);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.point_index = IDX_W'(index_w);
        o_cmd.last_point  = i_end_of_grid;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (full) begin
                        if (i_end_of_grid) begin
                            n_count = '0;
                        end
                    end else begin
                        o_cmd.shift_window = 1'b1;
                        n_count = i_end_of_grid ? '0 : r_count + CNT_W'(1);
                        if (r_count >= CNT_W'(2)) begin
                            o_cmd.load_ops = 1'b1;
                            n_state = S_MUL1;
                        end
                    end
                end
            end
            S_MUL1: begin
                o_cmd.mul1_en = 1'b1;
                n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum_en = 1'b1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2_en = 1'b1;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                if (out_free) begin
                    o_cmd.round_en = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    a_round_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.round_en |-> !(r_out_valid && i_out_stall))
        else $error("Result loaded while the output register was still held.");

    a_step_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL1) |=> (r_state == S_SUM))
        else $error("Multiply step was not followed by the sum step.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("Point count ran past the grid limit.");

    a_load_needs_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_ops |-> (r_count >= CNT_W'(2)) && !full)
        else $error("Stencil started without a full window.");

endmodule
`default_nettype wire

// ===== src/dws_datapath.sv =====
`default_nettype none
// ============================================================================
// dws_datapath
// Configuration registers, three-point window and the multi-step stencil
// arithmetic with rounding and saturation.
// ============================================================================
module dws_datapath
    import dws_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [COEF_W-1:0]           i_cfg_data,
    input  wire logic signed [SAMPLE_W-1:0]  i_phi_now,
    input  wire logic signed [SAMPLE_W-1:0]  i_phi_before,
    input  wire t_dp_cmd                     i_cmd,
    output logic signed [SAMPLE_W-1:0]       o_next_value,
    output logic [IDX_W-1:0]                 o_point_index,
    output logic                             o_last_point
);

    localparam logic [52:0] ROUND_BIAS = 53'(1) << 29;

    logic [COEF_W-1:0]          r_courant;
    logic [COEF_W-1:0]          r_keep;
    logic [COEF_W-1:0]          r_recip;
    logic signed [SAMPLE_W-1:0] r_win_mid;
    logic signed [SAMPLE_W-1:0] r_win_left;
    logic signed [SAMPLE_W-1:0] r_held_before;

    logic signed [SAMPLE_W-1:0] r_op_mid;
    logic signed [SAMPLE_W-1:0] r_op_before;
    logic signed [17:0]         r_lap;
    logic [IDX_W-1:0]           r_work_index;
    logic                       r_work_last;
    logic signed [32:0]         r_keep_prod;
    logic signed [34:0]         r_r2_prod;
    logic signed [35:0]         r_sum;
    logic [33:0]                r_plo;
    logic signed [34:0]         r_phi;

    logic signed [17:0]         lap_w;
    logic signed [52:0]         prod_w;
    logic signed [22:0]         q_w;
    logic signed [SAMPLE_W-1:0] sat_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_courant <= COURANT_RESET;
            r_keep    <= KEEP_RESET;
            r_recip   <= RECIP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_COURANT: r_courant <= i_cfg_data;
                CFG_KEEP:    r_keep    <= i_cfg_data;
                CFG_RECIP:   r_recip   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_mid     <= '0;
            r_win_left    <= '0;
            r_held_before <= '0;
        end else if (i_cmd.shift_window) begin
            r_win_left    <= r_win_mid;
            r_win_mid     <= i_phi_now;
            r_held_before <= i_phi_before;
        end
    end

    assign lap_w = 18'(r_win_left) + 18'(i_phi_now) - (18'(r_win_mid) <<< 1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_ops) begin
            r_op_mid     <= r_win_mid;
            r_op_before  <= r_held_before;
            r_lap        <= lap_w;
            r_work_index <= i_cmd.point_index;
            r_work_last  <= i_cmd.last_point;
        end
        if (i_cmd.mul1_en) begin
            r_keep_prod <= r_op_before * $signed({1'b0, r_keep});
            r_r2_prod   <= $signed({1'b0, r_courant}) * r_lap;
        end
        if (i_cmd.sum_en) begin
            r_sum <= (36'(r_op_mid) <<< 16) - 36'(r_keep_prod) + 36'(r_r2_prod);
        end
        if (i_cmd.mul2_en) begin
            r_plo <= r_sum[17:0] * r_recip;
            r_phi <= $signed(r_sum[35:18]) * $signed({1'b0, r_recip});
        end
    end

    assign prod_w = $signed((53'(r_phi) <<< 18) + 53'(r_plo) + ROUND_BIAS);
    assign q_w    = prod_w[52:30];

    always_comb begin
        if (q_w > 23'sd32767) begin
            sat_w = 16'sh7FFF;
        end else if (q_w < -23'sd32768) begin
            sat_w = 16'sh8000;
        end else begin
            sat_w = q_w[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.round_en) begin
            o_next_value  <= sat_w;
            o_point_index <= r_work_index;
            o_last_point  <= r_work_last;
        end
    end

endmodule
`default_nettype wire

// ===== src/damped_wave_stencil_step.sv =====
`default_nettype none
// ============================================================================
// damped_wave_stencil_step
// Streaming damped 1D wave stencil: keeps a three-point window and returns
// the next-timestep sample of every interior point of a grid line.
// ============================================================================
// A result is worked from the point that completes its window through a
// multiply step, a sum, a second multiply step and a rounding step, which
// waits while the output register is held. Input is stalled during this;
// points that yield none (first two of a line, overflow points) do not stall.
// Reset (synchronous, active low) restores the coefficient defaults and
// empties the window and point count.
module damped_wave_stencil_step
    import dws_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [COEF_W-1:0]           i_cfg_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic signed [SAMPLE_W-1:0]  i_phi_now,
    input  wire logic signed [SAMPLE_W-1:0]  i_phi_before,
    input  wire logic                        i_end_of_grid,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic signed [SAMPLE_W-1:0]       o_next_value,
    output logic [IDX_W-1:0]                 o_point_index,
    output logic                             o_last_point
);

    t_dp_cmd cmd;

    dws_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_end_of_grid (i_end_of_grid),
        .o_in_stall    (o_in_stall),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_cmd         (cmd)
    );

    dws_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_phi_now     (i_phi_now),
        .i_phi_before  (i_phi_before),
        .i_cmd         (cmd),
        .o_next_value  (o_next_value),
        .o_point_index (o_point_index),
        .o_last_point  (o_last_point)
    );

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Damped wave stencil testbench
// Streams grid lines into damped_wave_stencil_step with random idle cycles
// on both channels and compares every result transaction field by field
// against a fixed-point prediction of the stencil kept alongside the block.
// ----------------------------------------------------------------------------
module testbench;
    import dws_pkg::*;

    localparam int LINE_CAP      = MAX_POINTS_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int WATCHDOG_MAX  = 1000;
    localparam int PRINT_MAX     = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic [IDX_W-1:0]           index;
        logic                       last;
    } t_stencil_out;

    typedef struct {
        t_sample      now;
        t_sample      prev;
        bit           eog;
        bit           typed;
        t_stencil_out res;
    } t_probe;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [COEF_W-1:0]    i_cfg_data    = '0;
    logic                 i_in_valid    = 1'b0;
    logic                 o_in_stall;
    t_sample              i_phi_now     = '0;
    t_sample              i_phi_before  = '0;
    logic                 i_end_of_grid = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall   = 1'b0;
    t_sample              o_next_value;
    logic [IDX_W-1:0]     o_point_index;
    logic                 o_last_point;

    logic [COEF_W-1:0] r2_coef    = COURANT_RESET;
    logic [COEF_W-1:0] keep_coef  = KEEP_RESET;
    logic [COEF_W-1:0] recip_coef = RECIP_RESET;
    int                line_count = 0;
    t_sample           win_mid    = '0;
    t_sample           win_left   = '0;
    t_sample           mid_prev   = '0;

    t_stencil_out pending_results[$];
    int           error_count = 0;
    int           idle_cycles = 0;
    int           in_gap_max  = 5;
    int           out_gap_max = 5;
    int           out_hold    = 0;

    t_probe probes [0:20] = '{
        '{16'sd0, 16'sd0, 1'b0, 1'b0, '0},
        '{16'sd0, 16'sd0, 1'b0, 1'b0, '0},
        '{16'sd0, 16'sd0, 1'b1, 1'b1, {16'sd0, 12'd1, 1'b1}},
        '{16'sd4096, 16'sd0, 1'b0, 1'b0, '0},
        '{16'sd4096, 16'sd0, 1'b0, 1'b0, '0},
        '{16'sd4096, 16'sd0, 1'b1, 1'b1, {16'sd8192, 12'd1, 1'b1}},
        '{16'h7FFF, 16'h8000, 1'b0, 1'b0, '0},
        '{16'h7FFF, 16'h8000, 1'b0, 1'b0, '0},
        '{16'h7FFF, 16'h8000, 1'b1, 1'b1, {16'h7FFF, 12'd1, 1'b1}},
        '{16'h8000, 16'h7FFF, 1'b0, 1'b0, '0},
        '{16'h8000, 16'h7FFF, 1'b0, 1'b0, '0},
        '{16'h8000, 16'h7FFF, 1'b1, 1'b1, {16'h8000, 12'd1, 1'b1}},
        '{16'sd1234, -16'sd77, 1'b1, 1'b0, '0},
        '{-16'sd5, 16'sd300, 1'b0, 1'b0, '0},
        '{16'sd700, -16'sd900, 1'b1, 1'b0, '0},
        '{16'sd100, 16'sd50, 1'b0, 1'b0, '0},
        '{-16'sd2000, 16'sd1500, 1'b0, 1'b0, '0},
        '{16'sd3000, -16'sd2500, 1'b0, 1'b0, '0},
        '{16'h7FFF, -16'sd1, 1'b0, 1'b0, '0},
        '{16'h8000, 16'sd0, 1'b0, 1'b0, '0},
        '{16'h7FFF, 16'h7FFF, 1'b1, 1'b0, '0}
    };

    damped_wave_stencil_step i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_phi_now     (i_phi_now),
        .i_phi_before  (i_phi_before),
        .i_end_of_grid (i_end_of_grid),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_next_value  (o_next_value),
        .o_point_index (o_point_index),
        .o_last_point  (o_last_point)
    );

    always #4 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        if (error_count < PRINT_MAX) begin
            $display("%0t mismatch: %s", $realtime, what);
        end
        error_count++;
    endtask

    // Moves the window by one point, unless the line is full, and returns whether
    // that point completes an interior result, together with the expected result.
    function automatic bit advance_stencil(input t_sample now, input t_sample prev,
                                           input bit eog, output t_stencil_out res);
        longint lap;
        longint sum;
        longint prod;
        longint q;
        bit     hit;
        hit = 1'b0;
        res = '0;
        if (line_count >= LINE_CAP) begin
            if (eog) begin
                line_count = 0;
            end
            return 1'b0;
        end
        if (line_count >= 2) begin
            lap  = longint'(win_left) + longint'(now) - 2 * longint'(win_mid);
            sum  = longint'(win_mid) * 65536 - longint'(mid_prev) * longint'(keep_coef)
                 + longint'(r2_coef) * lap;
            prod = sum * longint'(recip_coef);
            q    = (prod + (64'sd1 <<< 29)) >>> 30;
            if (q > 32767) begin
                q = 32767;
            end
            if (q < -32768) begin
                q = -32768;
            end
            res.value = t_sample'(q);
            res.index = IDX_W'(line_count - 1);
            res.last  = eog;
            hit = 1'b1;
        end
        win_left   = win_mid;
        win_mid    = now;
        mid_prev   = prev;
        line_count = eog ? 0 : line_count + 1;
        return hit;
    endfunction

    task automatic send_point(input t_sample now, input t_sample prev, input bit eog,
                              input bit typed, input t_stencil_out typed_res);
        int           gap;
        bit           hit;
        t_stencil_out res;
        gap = $urandom_range(0, in_gap_max);
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_phi_now     <= now;
        i_phi_before  <= prev;
        i_end_of_grid <= eog;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        hit = advance_stencil(now, prev, eog, res);
        if (typed) begin
            pending_results.push_back(typed_res);
        end else if (hit) begin
            pending_results.push_back(res);
        end
    endtask

    function automatic t_sample pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2, 3: return t_sample'($urandom);
            default: return t_sample'($urandom_range(0, 8191)) - 16'sd4096;
        endcase
    endfunction

    task automatic send_line(input int len);
        t_stencil_out blank;
        blank = '0;
        for (int k = 0; k < len; k++) begin
            send_point(pick_sample(), pick_sample(), k == len - 1, 1'b0, blank);
        end
    endtask

    // Coefficients change only once the pipeline has drained.
    task automatic configure(input logic [COEF_W-1:0] r2, input logic [COEF_W-1:0] keep,
                             input logic [COEF_W-1:0] recip);
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SPARE;
        i_cfg_data  <= COEF_W'($urandom);
        @(posedge i_clk);
        i_cfg_index <= CFG_COURANT;
        i_cfg_data  <= r2;
        @(posedge i_clk);
        i_cfg_index <= CFG_KEEP;
        i_cfg_data  <= keep;
        @(posedge i_clk);
        i_cfg_index <= CFG_RECIP;
        i_cfg_data  <= recip;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        r2_coef    = r2;
        keep_coef  = keep;
        recip_coef = recip;
    endtask

    always @(posedge i_clk) begin
        int draw;
        if (!i_rst_n) begin
            out_hold    <= 0;
            i_out_stall <= 1'b0;
        end else if (o_out_valid && !i_out_stall) begin
            draw = $urandom_range(0, out_gap_max);
            out_hold    <= draw;
            i_out_stall <= (draw != 0);
        end else if (o_out_valid && i_out_stall) begin
            out_hold <= out_hold - 1;
            if (out_hold <= 1) begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_stencil_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result for point %0d", o_point_index));
            end else begin
                want = pending_results.pop_front();
                if (o_next_value !== want.value) begin
                    report_mismatch($sformatf("point %0d next_value %0d, expected %0d",
                                              want.index, o_next_value, want.value));
                end
                if (o_point_index !== want.index) begin
                    report_mismatch($sformatf("point_index %0d, expected %0d",
                                              o_point_index, want.index));
                end
                if (o_last_point !== want.last) begin
                    report_mismatch($sformatf("point %0d last_point %0b, expected %0b",
                                              want.index, o_last_point, want.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_MAX) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [COEF_W-1:0] presets [0:5][0:2];
        int sent;
        int len;
        presets = '{
            '{16'd16384, 16'd32768, 16'd32768},
            '{16'd0,     16'd32768, 16'd32768},
            '{16'd65535, 16'd0,     16'd65535},
            '{16'd0,     16'd0,     16'd0},
            '{16'd32768, 16'd16384, 16'd30000},
            '{16'd65535, 16'd65535, 16'd32768}
        };
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (probes[r]) begin
            send_point(probes[r].now, probes[r].prev, probes[r].eog,
                       probes[r].typed, probes[r].res);
        end
        i_in_valid <= 1'b0;

        for (int p = 0; p < 12; p++) begin
            if (p < 6) begin
                configure(presets[p][0], presets[p][1], presets[p][2]);
            end else begin
                configure(COEF_W'($urandom), COEF_W'($urandom_range(0, 32768)),
                          COEF_W'($urandom_range(0, 32768)));
            end
            case (p)
                0: begin
                    in_gap_max  = 0;
                    out_gap_max = 0;
                end
                1: begin
                    in_gap_max  = 2;
                    out_gap_max = 2;
                end
                default: begin
                    in_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 11);
                    out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 11);
                end
            endcase
            sent = 0;
            while (sent < 60) begin
                case ($urandom_range(0, 9))
                    0: len = 1;
                    1: len = 2;
                    default: len = $urandom_range(3, 24);
                endcase
                send_line(len);
                sent += len;
            end
            i_in_valid <= 1'b0;
        end

        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (12) @(posedge i_clk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
